[design/mono_note_priority_keyboard_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the mono note priority keyboard core
// Two shorthands for clocked assertions, disabled while the active-low reset is low.
// ---------------------------------------------------------------------------
`ifndef MONO_NOTE_PRIORITY_KEYBOARD_CORE_ASSERT_SVH
`define MONO_NOTE_PRIORITY_KEYBOARD_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define MNPK_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define MNPK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/mnpk_pkg.sv]
// ---------------------------------------------------------------------------
// mnpk_pkg
// Shared constants and types for the mono note priority keyboard core.
// ---------------------------------------------------------------------------
package mnpk_pkg;

    // default depth of the note stack
    localparam int STACK_DEPTH_DEF = 8;

    // audio midpoint and volume limits
    localparam logic [11:0] MID      = 12'd2048;
    localparam logic [6:0]  VOL_MAX  = 7'd100;
    localparam logic [6:0]  VOL_STEP = 7'd10;

    // divide by 100: floor(x / 100) == (x * RECIP) >> RECIP_SHIFT for x < 2^18
    localparam int          PROD_W      = 18;
    localparam int          RECIP_W     = 19;
    localparam int          RECIP_SHIFT = 25;
    localparam logic [RECIP_W-1:0] RECIP = 19'd335545;

    // reset key ids of the control buttons
    localparam logic [7:0] KEY_SETTINGS_RST = 8'd252;
    localparam logic [7:0] KEY_UP_RST       = 8'd253;
    localparam logic [7:0] KEY_DOWN_RST     = 8'd254;
    localparam logic [7:0] KEY_ENTER_RST    = 8'd255;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SETTINGS = 2'd0,
        CFG_UP       = 2'd1,
        CFG_DOWN     = 2'd2,
        CFG_ENTER    = 2'd3
    } t_cfg_idx;

endpackage

[design/mono_note_priority_keyboard_core.sv]
// ---------------------------------------------------------------------------
// mono_note_priority_keyboard_core
// Monophonic keyboard controller, last-note priority. Held notes sit in a
// small synchronous RAM, walked by a sequencer; sample items are scaled by
// the volume with a two-step multiply-by-reciprocal.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                    | payload
//  in      | input     | i_in_valid / o_in_ready      | cmd, key_id, pressed, raw_sample
//  out     | output    | o_out_valid / i_out_ready    | dac_value .. pending_wave
//  cfg     | input     | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_data
//
//  Sample item: DECODE, MUL (multiply), RECIP (reciprocal), SCALE; with an
//  empty stack it goes from DECODE to DONE at midpoint. Key item: control keys
//  go from DECODE to DONE; note keys walk the RAM one entry a cycle.
//  One item is in work at a time; the next is taken while a result waits.
//  A result that is not taken holds the sequencer in its final state.
//  Reset (synchronous, active low) empties the stack; RAM needs no clearing.
// ---------------------------------------------------------------------------
module mono_note_priority_keyboard_core #(
    parameter int STACK_DEPTH = mnpk_pkg::STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_key_id,
    input  logic        i_pressed,
    input  logic [11:0] i_raw_sample,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [11:0] o_dac_value,
    output logic [7:0]  o_top_note,
    output logic        o_note_active,
    output logic [6:0]  o_volume_pct,
    output logic [1:0]  o_wave_type,
    output logic        o_adjusting,
    output logic [1:0]  o_pending_wave
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int MW = mnpk_pkg::PROD_W + mnpk_pkg::RECIP_W;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_SCAN   = 9'b000000100,
        S_SHIFT  = 9'b000001000,
        S_TOP    = 9'b000010000,
        S_MUL    = 9'b000100000,
        S_RECIP  = 9'b001000000,
        S_SCALE  = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // captured item
    logic        r_cmd, r_pressed;
    logic [7:0]  r_id;
    logic [11:0] r_raw;

    // control key ids
    logic [7:0] r_key_set, r_key_up, r_key_dn, r_key_ent;

    // keyboard state
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx, n_idx;
    logic [7:0]    r_top, n_top;
    logic [6:0]    r_vol, n_vol;
    logic [1:0]    r_wave, n_wave;
    logic [1:0]    r_pend, n_pend;
    logic          r_adj, n_adj;

    // sample path
    logic [mnpk_pkg::PROD_W-1:0] r_prod, n_prod;
    logic [11:0] r_quot, n_quot;
    logic        r_neg, n_neg;
    logic [11:0] r_dac, n_dac;

    // output register
    logic        r_out_valid, n_out_valid;
    logic        w_load;

    // note RAM
    logic [7:0]    mem [STACK_DEPTH];
    logic [7:0]    r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;

    // helpers
    logic [CW-1:0] w_last, w_below, w_idx_ext, w_nx_ext;
    logic [AW-1:0] w_idx_nx, w_idx_nx2;
    logic          w_at_last, w_match, w_full;
    logic          w_is_set, w_is_up, w_is_dn, w_is_ent, w_is_ctrl;
    logic signed [12:0] w_center;
    logic [12:0]   w_abs;
    logic [MW-1:0] w_scaled;

    assign o_in_ready = (r_state == S_IDLE);

    assign w_last    = r_count - CW'(1);
    assign w_below   = r_count - CW'(2);
    assign w_idx_ext = CW'(r_idx);
    assign w_nx_ext  = w_idx_ext + CW'(1);
    assign w_idx_nx  = r_idx + AW'(1);
    assign w_idx_nx2 = w_idx_nx + AW'(1);
    assign w_at_last = (w_idx_ext == w_last);
    assign w_match   = (r_rdata == r_id);
    assign w_full    = (r_count == CW'(STACK_DEPTH));

    assign w_is_set  = (r_id == r_key_set);
    assign w_is_up   = (r_id == r_key_up);
    assign w_is_dn   = (r_id == r_key_dn);
    assign w_is_ent  = (r_id == r_key_ent);
    assign w_is_ctrl = w_is_set | w_is_up | w_is_dn | w_is_ent;

    assign w_center = $signed({1'b0, r_raw}) - $signed({1'b0, mnpk_pkg::MID});
    assign w_abs    = w_center[12] ? 13'(-w_center) : 13'(w_center);
    assign w_scaled = MW'(r_prod) * MW'(mnpk_pkg::RECIP);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_top       = r_top;
        n_vol       = r_vol;
        n_wave      = r_wave;
        n_pend      = r_pend;
        n_adj       = r_adj;
        n_prod      = r_prod;
        n_quot      = r_quot;
        n_neg       = r_neg;
        n_dac       = r_dac;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = r_id;
        mem_raddr   = r_idx;
        w_load      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_dac = mnpk_pkg::MID;
                if (r_cmd) begin
                    n_state = (r_count != '0) ? S_MUL : S_DONE;
                end else if (w_is_ctrl) begin
                    n_state = S_DONE;
                    if (r_pressed) begin
                        priority if (w_is_set) begin
                            n_pend = r_wave;
                            n_adj  = ~r_adj;
                        end else if (w_is_up) begin
                            if (r_adj) begin
                                n_pend = r_pend + 2'd1;
                            end else if (r_vol < mnpk_pkg::VOL_MAX) begin
                                n_vol = r_vol + mnpk_pkg::VOL_STEP;
                            end
                        end else if (w_is_dn) begin
                            if (r_adj) begin
                                n_pend = r_pend - 2'd1;
                            end else if (r_vol != '0) begin
                                n_vol = (r_vol >= mnpk_pkg::VOL_STEP) ?
                                        r_vol - mnpk_pkg::VOL_STEP : '0;
                            end
                        end else begin
                            if (r_adj) begin
                                n_wave  = r_pend;
                                n_count = '0;
                                n_adj   = 1'b0;
                            end
                        end
                    end
                end else if (r_count == '0) begin
                    // empty stack: a press goes straight into entry zero
                    n_state = S_DONE;
                    if (r_pressed) begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        n_count   = CW'(1);
                        n_top     = r_id;
                    end
                end else begin
                    mem_raddr = '0;
                    n_idx     = '0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_match) begin
                    if (r_pressed) begin
                        n_state = S_DONE;               // already held
                    end else if (w_at_last) begin
                        // released the top: fetch the one below
                        n_count = w_last;
                        if (w_last == '0) begin
                            n_state = S_DONE;
                        end else begin
                            mem_raddr = w_below[AW-1:0];
                            n_state   = S_TOP;
                        end
                    end else begin
                        mem_raddr = w_idx_nx;
                        n_state   = S_SHIFT;
                    end
                end else if (w_at_last) begin
                    n_state = S_DONE;
                    if (r_pressed && !w_full) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_count[AW-1:0];
                        n_count   = r_count + CW'(1);
                        n_top     = r_id;
                    end
                end else begin
                    mem_raddr = w_idx_nx;
                    n_idx     = w_idx_nx;
                end
            end
            S_SHIFT: begin
                // close the gap: entry idx takes entry idx + 1
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_rdata;
                if (w_nx_ext == w_last) begin
                    n_count = w_last;
                    n_top   = r_rdata;
                    n_state = S_DONE;
                end else begin
                    mem_raddr = w_idx_nx2;
                    n_idx     = w_idx_nx;
                end
            end
            S_TOP: begin
                n_top   = r_rdata;
                n_state = S_DONE;
            end
            S_MUL: begin
                n_neg   = w_center[12];
                n_prod  = mnpk_pkg::PROD_W'(w_abs[11:0]) * mnpk_pkg::PROD_W'(r_vol);
                n_state = S_RECIP;
            end
            S_RECIP: begin
                n_quot  = w_scaled[mnpk_pkg::RECIP_SHIFT +: 12];
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_dac   = r_neg ? mnpk_pkg::MID - r_quot : mnpk_pkg::MID + r_quot;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output slot
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_vol       <= mnpk_pkg::VOL_MAX;
            r_wave      <= '0;
            r_pend      <= '0;
            r_adj       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_vol       <= n_vol;
            r_wave      <= n_wave;
            r_pend      <= n_pend;
            r_adj       <= n_adj;
            r_out_valid <= n_out_valid;
        end
    end

    // control key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_set <= mnpk_pkg::KEY_SETTINGS_RST;
            r_key_up  <= mnpk_pkg::KEY_UP_RST;
            r_key_dn  <= mnpk_pkg::KEY_DOWN_RST;
            r_key_ent <= mnpk_pkg::KEY_ENTER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mnpk_pkg::CFG_SETTINGS: r_key_set <= i_cfg_data;
                mnpk_pkg::CFG_UP:       r_key_up  <= i_cfg_data;
                mnpk_pkg::CFG_DOWN:     r_key_dn  <= i_cfg_data;
                mnpk_pkg::CFG_ENTER:    r_key_ent <= i_cfg_data;
                default:                r_key_ent <= r_key_ent;
            endcase
        end
    end

    // item capture and datapath
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd     <= i_cmd;
            r_id      <= i_key_id;
            r_pressed <= i_pressed;
            r_raw     <= i_raw_sample;
        end
        r_idx  <= n_idx;
        r_top  <= n_top;
        r_prod <= n_prod;
        r_quot <= n_quot;
        r_neg  <= n_neg;
        r_dac  <= n_dac;
    end

    // note RAM, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    // result register, snapshot after the update
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_dac_value    <= r_dac;
            o_top_note     <= (r_count != '0) ? r_top : 8'd0;
            o_note_active  <= (r_count != '0);
            o_volume_pct   <= r_vol;
            o_wave_type    <= r_wave;
            o_adjusting    <= r_adj;
            o_pending_wave <= r_pend;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[design/mnpk_checker.sv]
// ---------------------------------------------------------------------------
// mnpk_port_checker
// Port-level checks on the keyboard core, bound to every instance.
// ---------------------------------------------------------------------------
`include "mono_note_priority_keyboard_core_assert.svh"

module mnpk_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [11:0] o_dac_value,
    input logic [7:0]  o_top_note,
    input logic        o_note_active,
    input logic [6:0]  o_volume_pct
);

    // one item in work at a time: taking an item closes the input
    `MNPK_ASSERT_NEXT(a_one_in_work, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "item taken while another in work")

    // a stalled result holds
    `MNPK_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_dac_value) && $stable(o_top_note), "stalled result changed")

    // empty stack: silent output, no top note
    `MNPK_ASSERT_NOW(a_silent, i_clk, i_rst_n, o_out_valid && !o_note_active, o_dac_value == mnpk_pkg::MID && o_top_note == 8'd0, "empty stack not silent")

    // volume never leaves its range
    `MNPK_ASSERT_NOW(a_vol_range, i_clk, i_rst_n, o_out_valid, o_volume_pct <= mnpk_pkg::VOL_MAX, "volume out of range")

endmodule

bind mono_note_priority_keyboard_core mnpk_port_checker u_mnpk_port_checker (.*);
